// File: rtl/hftl_pkg.sv
package hftl_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_RECORD_BITS   = 64;

    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 7;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FETCH   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// File: rtl/hftl_if.sv
interface hftl_req_if
    import hftl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   paint_data;

    modport source (output valid, command, handle, paint_data, input ready);
    modport sink   (input valid, command, handle, paint_data, output ready);
endinterface

interface hftl_rsp_if
    import hftl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [DATA_W-1:0]   paint_out;

    modport source (output valid, status, handle_out, paint_out, input ready);
    modport sink   (input valid, status, handle_out, paint_out, output ready);
endinterface

// File: rtl/hftl_ram.sv
module hftl_ram
    import hftl_pkg::*;
#(
    parameter int WIDTH = DEF_RECORD_BITS,
    parameter int DEPTH = DEF_TABLE_ENTRIES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hftl_ctrl.sv
module hftl_ctrl
    import hftl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int RECORD_BITS   = DEF_RECORD_BITS,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int PTR_W        = $clog2(TABLE_ENTRIES + 1),
    localparam int META_W       = PTR_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    hftl_req_if.sink               req,
    hftl_rsp_if.source             rsp,
    output logic                   meta_we,
    output logic [IDX_W-1:0]       meta_waddr,
    output logic [META_W-1:0]      meta_wdata,
    output logic                   meta_re,
    output logic [IDX_W-1:0]       meta_raddr,
    input  logic [META_W-1:0]      meta_rdata,
    output logic                   paint_we,
    output logic [IDX_W-1:0]       paint_waddr,
    output logic [RECORD_BITS-1:0] paint_wdata,
    output logic                   paint_re,
    output logic [IDX_W-1:0]       paint_raddr,
    input  logic [RECORD_BITS-1:0] paint_rdata
);

    localparam int CMP_W = (PTR_W > HANDLE_W) ? PTR_W : HANDLE_W;
    localparam logic [PTR_W-1:0] LIST_END = PTR_W'(TABLE_ENTRIES);

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      fill_reg, fill_next;
    logic                  out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic                  range_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [RECORD_BITS-1:0] data_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [HANDLE_W-1:0]   hout_reg, hout_next;
    logic [DATA_W-1:0]     pout_reg, pout_next;

    logic                  accept;
    logic                  go;
    logic                  head_free;
    logic [CMP_W-1:0]      hx;
    logic [CMP_W-1:0]      hm1;
    logic [CMP_W-1:0]      hsum;
    logic                  h_in_range;
    logic [IDX_W-1:0]      acc_slot;
    logic                  slot_live;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign head_free  = (head_reg < LIST_END);
    assign hx         = CMP_W'(req.handle);
    assign hm1        = hx - CMP_W'(1);
    assign h_in_range = (hx != '0) && (hx <= CMP_W'(TABLE_ENTRIES));
    assign hsum       = CMP_W'(head_reg) + CMP_W'(1);
    assign slot_live  = range_reg && (PTR_W'(slot_reg) < fill_reg) && meta_rdata[PTR_W];

    always_comb
    begin
        if (cmd_t'(req.command) == CMD_ALLOC)
        begin
            acc_slot = head_free ? head_reg[IDX_W-1:0] : '0;
        end
        else
        begin
            acc_slot = h_in_range ? hm1[IDX_W-1:0] : '0;
        end
    end

    assign meta_re     = accept;
    assign paint_re    = accept;
    assign meta_raddr  = acc_slot;
    assign paint_raddr = acc_slot;
    assign meta_waddr  = slot_reg;
    assign paint_waddr = slot_reg;
    assign paint_wdata = data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        status_next    = ST_BAD_HANDLE;
        hout_next      = '0;
        pout_next      = '0;
        meta_we        = 1'b0;
        meta_wdata     = '0;
        paint_we       = 1'b0;
        go             = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd_t'(cmd_reg))
            CMD_ALLOC:
            begin
                if (!head_free)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    hout_next   = hsum[HANDLE_W-1:0];
                    meta_wdata  = {1'b1, {PTR_W{1'b0}}};
                    if (go)
                    begin
                        meta_we  = 1'b1;
                        paint_we = 1'b1;
                        if (head_reg < fill_reg)
                        begin
                            head_next = meta_rdata[PTR_W-1:0];
                        end
                        else
                        begin
                            head_next = head_reg + PTR_W'(1);
                            fill_next = fill_reg + PTR_W'(1);
                        end
                    end
                end
            end
            CMD_FETCH:
            begin
                if (slot_live)
                begin
                    status_next = ST_OK;
                    pout_next   = DATA_W'(paint_rdata);
                end
            end
            CMD_RELEASE:
            begin
                if (slot_live)
                begin
                    status_next = ST_OK;
                    meta_wdata  = {1'b0, head_reg};
                    if (go)
                    begin
                        meta_we   = 1'b1;
                        head_next = PTR_W'(slot_reg);
                    end
                end
            end
            default:
            begin
                status_next = ST_BAD_HANDLE;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            range_reg <= h_in_range;
            slot_reg  <= acc_slot;
            data_reg  <= req.paint_data[RECORD_BITS-1:0];
        end
        if (go)
        begin
            status_reg <= status_next;
            hout_reg   <= hout_next;
            pout_reg   <= pout_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.handle_out = hout_reg;
    assign rsp.paint_out  = pout_reg;

endmodule

// File: rtl/handle_table_free_list.sv
// Channel | Dir | Transfer carries
// --------+-----+-----------------------------------------------
// req     | in  | command, handle, paint_data
// rsp     | out | status, handle_out, paint_out
//
// Each transfer first reads the link/live memory and the record memory at
// the slot, then checks, writes back and registers the result.
// Reset clears the free-list head and the fill count at once; entries at or
// above the fill count read as linked in order and dead, so no clearing pass.
// A result left untaken in the output register holds the check step; the
// input takes a new transfer as soon as the result is registered.
module handle_table_free_list
    import hftl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int RECORD_BITS   = DEF_RECORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    hftl_req_if.sink   req,
    hftl_rsp_if.source rsp
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int PTR_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int META_W = PTR_W + 1;

    logic                   meta_we;
    logic [IDX_W-1:0]       meta_waddr;
    logic [META_W-1:0]      meta_wdata;
    logic                   meta_re;
    logic [IDX_W-1:0]       meta_raddr;
    logic [META_W-1:0]      meta_rdata;
    logic                   paint_we;
    logic [IDX_W-1:0]       paint_waddr;
    logic [RECORD_BITS-1:0] paint_wdata;
    logic                   paint_re;
    logic [IDX_W-1:0]       paint_raddr;
    logic [RECORD_BITS-1:0] paint_rdata;

    hftl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .RECORD_BITS   (RECORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .meta_re     (meta_re),
        .meta_raddr  (meta_raddr),
        .meta_rdata  (meta_rdata),
        .paint_we    (paint_we),
        .paint_waddr (paint_waddr),
        .paint_wdata (paint_wdata),
        .paint_re    (paint_re),
        .paint_raddr (paint_raddr),
        .paint_rdata (paint_rdata)
    );

    hftl_ram #(
        .WIDTH (META_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    hftl_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_paint_ram (
        .clk   (clk),
        .we    (paint_we),
        .waddr (paint_waddr),
        .wdata (paint_wdata),
        .re    (paint_re),
        .raddr (paint_raddr),
        .rdata (paint_rdata)
    );

endmodule

// File: rtl/hftl_checker.sv
module hftl_checker
    import hftl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [HANDLE_W-1:0] handle_out,
    input logic [DATA_W-1:0]   paint_out
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken again in the cycle after a transfer");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL || status == ST_BAD_HANDLE)
            |-> handle_out == '0 && paint_out == '0)
        else $error("failed result carries a handle or a record");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK || status == ST_BAD_HANDLE || status == ST_FULL))
        else $error("unknown status code");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(handle_out) && $stable(paint_out))
        else $error("stalled result changed");

endmodule

bind handle_table_free_list hftl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .handle_out (rsp.handle_out),
    .paint_out  (rsp.paint_out)
);
